### hw/rtl/mcp_pkg.sv
// Shared constants and types for the max-cut-pieces block.
package mcp_pkg;

  localparam int LEN_W       = 12;
  localparam int CNT_W       = LEN_W;
  localparam int MAX_LENGTH  = 4095;
  localparam int TABLE_DEPTH = MAX_LENGTH + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = CNT_W + 1;
  localparam int NUM_PIECES  = 3;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic publish;
  } mcp_cmd_t;

  typedef struct packed {
    logic skip;
    logic last_issue;
  } mcp_sts_t;

endpackage

### hw/rtl/mcp_if.sv
// Input and output channel interfaces of the max-cut-pieces block.
interface mcp_in_if import mcp_pkg::*; ();
  logic valid;
  logic ready;
  len_t total_length;
  len_t piece_a;
  len_t piece_b;
  len_t piece_c;

  modport source (output valid, total_length, piece_a, piece_b, piece_c, input ready);
  modport sink (input valid, total_length, piece_a, piece_b, piece_c, output ready);
endinterface

interface mcp_out_if import mcp_pkg::*; ();
  logic valid;
  logic ready;
  len_t max_pieces;

  modport source (output valid, max_pieces, input ready);
  modport sink (input valid, max_pieces, output ready);
endinterface

### hw/rtl/mcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mcp_dpath.sv
// Datapath: operand registers, table copies, two-stage entry fill and result registers.
module mcp_dpath import mcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mcp_cmd_t cmd,
  output mcp_sts_t sts,
  input  len_t     total_length,
  input  len_t     piece_a,
  input  len_t     piece_b,
  input  len_t     piece_c,
  output len_t     max_pieces
);

  len_t   total;
  len_t   piece [NUM_PIECES];
  len_t   rd_idx;
  logic   pv;
  len_t   wr_idx;
  logic [NUM_PIECES-1:0] use_q;
  logic [NUM_PIECES-1:0] zero_q;
  logic [NUM_PIECES-1:0] fwd_q;
  entry_t last_entry;
  len_t   ans;

  len_t   rd_addr [NUM_PIECES];
  logic [NUM_PIECES-1:0] use_d;
  logic [NUM_PIECES-1:0] zero_d;
  logic [NUM_PIECES-1:0] fwd_d;
  entry_t q [NUM_PIECES];
  entry_t prev [NUM_PIECES];
  logic [NUM_PIECES-1:0] ok;
  len_t   cand [NUM_PIECES];
  len_t   best;
  logic   any_ok;
  entry_t wr_entry;

  assign sts.skip = (total_length == '0) || (total_length > LEN_W'(MAX_LENGTH));
  assign sts.last_issue = (rd_idx == total);

  // Issue stage: table address for each piece at the current length.
  always_comb begin
    for (int k = 0; k < NUM_PIECES; k++) begin
      rd_addr[k] = rd_idx - piece[k];
      use_d[k]   = (piece[k] != '0) && (piece[k] <= rd_idx);
      zero_d[k]  = (rd_addr[k] == '0);
      // entry one below is written in the same cycle as this read: forward it
      fwd_d[k]   = (piece[k] == LEN_W'(1));
    end
  end

  for (genvar k = 0; k < NUM_PIECES; k++) begin : g_tbl
    mcp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (pv),
      .waddr (IDX_W'(wr_idx)),
      .wdata (wr_entry),
      .raddr (IDX_W'(rd_addr[k])),
      .rdata (q[k])
    );
  end

  // Update stage: best count over usable pieces, top bit marks unreachable.
  always_comb begin
    best   = '0;
    any_ok = 1'b0;
    for (int k = 0; k < NUM_PIECES; k++) begin
      prev[k] = zero_q[k] ? '0 : (fwd_q[k] ? last_entry : q[k]);
      ok[k]   = use_q[k] && !prev[k][ENTRY_W-1];
      cand[k] = prev[k][CNT_W-1:0] + CNT_W'(1);
      if (ok[k] && (!any_ok || (cand[k] > best))) begin
        best   = cand[k];
        any_ok = 1'b1;
      end
    end
    wr_entry = {!any_ok, best};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total    <= total_length;
      piece[0] <= piece_a;
      piece[1] <= piece_b;
      piece[2] <= piece_c;
      rd_idx   <= LEN_W'(1);
      ans      <= '0;
    end
    if (cmd.issue) begin
      rd_idx <= rd_idx + LEN_W'(1);
      wr_idx <= rd_idx;
      use_q  <= use_d;
      zero_q <= zero_d;
      fwd_q  <= fwd_d;
    end
    if (pv) begin
      last_entry <= wr_entry;
      if (wr_idx == total) begin
        ans <= any_ok ? best : '0;
      end
    end
    if (cmd.publish) begin
      max_pieces <= ans;
    end
  end

endmodule

### hw/rtl/mcp_ctrl.sv
// Controller: sequences table fill per word and owns the result handshake.
module mcp_ctrl import mcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  mcp_sts_t sts,
  output mcp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FILL   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_valid;

  assign out_valid = res_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.skip ? S_FINISH : S_FILL;
        end
      end
      S_FILL: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!res_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_fill_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) && sts.last_issue |=> (state == S_DRAIN))
    else $error("fill did not stop after the last entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!res_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ready |=> res_valid)
    else $error("pending result dropped");

endmodule

### hw/rtl/max_cut_pieces_dp.sv
// Max-cut-pieces top level: controller plus table datapath.
// Each input word gives a total length and three piece lengths (0 = unusable);
// the result word is the greatest number of pieces, repeats allowed, whose
// lengths sum exactly to the total, or 0 when none exists or the total is 0.
// The block works on one word at a time: it fills a table of best counts for
// lengths 1..total_length at one entry per cycle, then passes through a drain
// state and a finish state that publishes the result into the output register
// once it is free, before the next word is taken; a word with a zero total
// skips the fill and goes straight to the finish state. The fill rate is set
// by the table, kept as three identical RAM copies so each entry reads its
// three predecessors together. The table needs no clearing after reset. A
// finished result sits in an output register, so the next word is taken while
// it waits.
module max_cut_pieces_dp import mcp_pkg::*; (
  input logic      clk,
  input logic      rst,
  mcp_in_if.sink   cut_in,
  mcp_out_if.source cut_out
);

  mcp_cmd_t cmd;
  mcp_sts_t sts;

  mcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cut_in.valid),
    .in_ready  (cut_in.ready),
    .out_valid (cut_out.valid),
    .out_ready (cut_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .total_length (cut_in.total_length),
    .piece_a      (cut_in.piece_a),
    .piece_b      (cut_in.piece_b),
    .piece_c      (cut_in.piece_c),
    .max_pieces   (cut_out.max_pieces)
  );

endmodule

### bench/max_cut_pieces_dp_tb.sv
// Testbench for max_cut_pieces_dp: directed and random words, predicted counts, checked results.
module max_cut_pieces_dp_tb;
  import mcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_WORDS = 122;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 4200;
  localparam int CYCLE_LIMIT  = 4000000;

  typedef enum int {
    PHASE_SENDER_LIGHT,
    PHASE_SENDER_HEAVY,
    PHASE_NO_IDLE
  } idle_phase_t;

  typedef struct packed {
    len_t total_length;
    len_t piece_a;
    len_t piece_b;
    len_t piece_c;
  } cut_word_t;

  logic clk;
  logic rst = 1'b1;

  mcp_in_if  cut_in ();
  mcp_out_if cut_out ();

  max_cut_pieces_dp dut (
    .clk     (clk),
    .rst     (rst),
    .cut_in  (cut_in.sink),
    .cut_out (cut_out.source)
  );

  cut_word_t cut_words_q[$];
  len_t      max_pieces_q[$];
  int        total_words;
  int        words_accepted;
  int        hold_left;
  bit        hold_done;
  int        errors;
  int        cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Greatest piece count summing exactly to the total; -1 marks an unreachable length.
  function automatic len_t predict_max_pieces(cut_word_t w);
    int best_at [0:MAX_LENGTH];
    int piece [NUM_PIECES];
    int total;
    int i;
    int k;
    int prev;
    total = w.total_length;
    piece[0] = w.piece_a;
    piece[1] = w.piece_b;
    piece[2] = w.piece_c;
    if (total == 0) return '0;
    best_at[0] = 0;
    for (i = 1; i <= total; i++) begin
      best_at[i] = -1;
      for (k = 0; k < NUM_PIECES; k++) begin
        if (piece[k] != 0 && piece[k] <= i) begin
          prev = best_at[i - piece[k]];
          if (prev >= 0 && prev + 1 > best_at[i]) best_at[i] = prev + 1;
        end
      end
    end
    if (best_at[total] < 0) return '0;
    return len_t'(best_at[total]);
  endfunction

  function automatic cut_word_t make_word(int total, int a, int b, int c);
    cut_word_t w;
    w.total_length = len_t'(total);
    w.piece_a = len_t'(a);
    w.piece_b = len_t'(b);
    w.piece_c = len_t'(c);
    return w;
  endfunction

  function automatic len_t random_piece();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) return '0;
    if (pick < 22) return len_t'($urandom);
    return len_t'($urandom_range(24, 1));
  endfunction

  // Keep most totals short; a few span the full field.
  function automatic cut_word_t random_word();
    cut_word_t w;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 8) w.total_length = '0;
    else if (pick < 18) w.total_length = len_t'($urandom);
    else w.total_length = len_t'($urandom_range(255, 1));
    w.piece_a = random_piece();
    w.piece_b = random_piece();
    w.piece_c = random_piece();
    return w;
  endfunction

  function automatic int idle_pct(bit receiver_side);
    idle_phase_t phase;
    if (words_accepted < total_words / 3) phase = PHASE_SENDER_LIGHT;
    else if (words_accepted < 2 * total_words / 3) phase = PHASE_SENDER_HEAVY;
    else phase = PHASE_NO_IDLE;
    case (phase)
      PHASE_SENDER_LIGHT: return receiver_side ? 58 : 17;
      PHASE_SENDER_HEAVY: return receiver_side ? 17 : 58;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Driver: present the next word once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      cut_in.valid <= 1'b0;
    end else begin
      if (cut_in.valid && cut_in.ready) begin
        max_pieces_q.push_back(predict_max_pieces(make_word(cut_in.total_length,
          cut_in.piece_a, cut_in.piece_b, cut_in.piece_c)));
        words_accepted <= words_accepted + 1;
      end
      if (!cut_in.valid || cut_in.ready) begin
        if (cut_words_q.size() > 0 && $urandom_range(99, 0) >= idle_pct(1'b0)) begin
          cut_in.total_length <= cut_words_q[0].total_length;
          cut_in.piece_a      <= cut_words_q[0].piece_a;
          cut_in.piece_b      <= cut_words_q[0].piece_b;
          cut_in.piece_c      <= cut_words_q[0].piece_c;
          cut_in.valid        <= 1'b1;
          void'(cut_words_q.pop_front());
        end else begin
          cut_in.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the block fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      cut_out.ready <= 1'b0;
    end else begin
      if (cut_out.valid && cut_out.ready) begin
        if (max_pieces_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result max_pieces=%0d", cut_out.max_pieces));
        end else begin
          if (cut_out.max_pieces !== max_pieces_q[0])
            report_mismatch($sformatf("max_pieces got %0d, want %0d",
              cut_out.max_pieces, max_pieces_q[0]));
          void'(max_pieces_q.pop_front());
        end
      end
      cut_out.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    errors = 0;
    cycle_cnt = 0;
    words_accepted = 0;
    cut_in.valid = 1'b0;
    cut_in.total_length = '0;
    cut_in.piece_a = '0;
    cut_in.piece_b = '0;
    cut_in.piece_c = '0;
    cut_out.ready = 1'b0;

    cut_words_q.push_back(make_word(0, 1, 2, 3));          // zero total
    cut_words_q.push_back(make_word(0, 0, 0, 0));
    cut_words_q.push_back(make_word(4095, 1, 1, 1));       // widest count
    cut_words_q.push_back(make_word(4095, 0, 0, 0));       // no usable piece
    cut_words_q.push_back(make_word(4095, 4095, 4095, 4095));
    cut_words_q.push_back(make_word(7, 8, 9, 4095));       // every piece too long
    cut_words_q.push_back(make_word(5, 0, 2, 0));          // unreachable total
    cut_words_q.push_back(make_word(10, 0, 0, 5));
    cut_words_q.push_back(make_word(1, 1, 0, 0));
    cut_words_q.push_back(make_word(4094, 2048, 2046, 4095));
    cut_words_q.push_back(make_word(2730, 1365, 2730, 2047));
    cut_words_q.push_back(make_word(4095, 2048, 1024, 512));
    cut_words_q.push_back(make_word(1365, 3, 5, 7));
    cut_words_q.push_back(make_word(23, 5, 5, 5));
    cut_words_q.push_back(make_word(4095, 4094, 1, 0));
    cut_words_q.push_back(make_word(4095, 3, 4095, 2));
    cut_words_q.push_back(make_word(100, 7, 11, 13));
    cut_words_q.push_back(make_word(2, 4095, 0, 1));
    for (n = 0; n < RANDOM_WORDS; n++) cut_words_q.push_back(random_word());
    total_words = cut_words_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cut_words_q.size() != 0 || cut_in.valid || max_pieces_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_if.sv
hw/rtl/mcp_ram.sv
hw/rtl/mcp_dpath.sv
hw/rtl/mcp_ctrl.sv
hw/rtl/max_cut_pieces_dp.sv
bench/max_cut_pieces_dp_tb.sv
